>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define TKEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define TKEQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/tkeq_pkg.sv
// ----------------------------------------------------------------------------
// Timed kill event queue package
// Sizes, codes and the control types shared by the queue modules.
// ----------------------------------------------------------------------------
package tkeq_pkg;

  localparam int DEPTH   = 16;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ID_W    = 16;
  localparam int TIME_W  = 31;
  localparam int ENTRY_W = ID_W + TIME_W;

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_TICK = 1'b1
  } act_t;

  typedef enum logic [1:0] {
    KIND_ADD_OK   = 2'd0,
    KIND_ADD_FULL = 2'd1,
    KIND_FIRED    = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NONE,
    ST_EMIT
  } state_t;

  // One accepted input item handed to the engine.
  typedef struct packed {
    logic              valid;
    act_t              action;
    logic [ID_W-1:0]   target_id;
    logic [TIME_W-1:0] event_time;
    logic [TIME_W-1:0] tick_time;
  } cmd_t;

  // One result produced by the engine for the output register.
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [ID_W-1:0]   fired_id;
    logic [TIME_W-1:0] fired_time;
    logic              last;
    logic              pending;
  } res_t;

endpackage

>>> src/tkeq_if.sv
// ----------------------------------------------------------------------------
// Timed kill event queue channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tkeq_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] target_id;
  logic [30:0] event_time;
  logic [30:0] tick_time;

  modport source (output valid, action, target_id, event_time, tick_time,
                  input ready);
  modport sink (input valid, action, target_id, event_time, tick_time,
                output ready);
endinterface

interface tkeq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] fired_id;
  logic [30:0] fired_time;
  logic        last;
  logic        pending;

  modport source (output valid, kind, fired_id, fired_time, last, pending,
                  input ready);
  modport sink (input valid, kind, fired_id, fired_time, last, pending,
                output ready);
endinterface

>>> src/timed_kill_event_queue_top.sv
// ----------------------------------------------------------------------------
// Timed kill event queue, top level
// Stores pending events in a memory, fires those due exactly at a tick.
// ----------------------------------------------------------------------------
//  channel | direction | transfer carries
//  --------+-----------+----------------------------------------------------
//  in_ch   | in        | action, target_id, event_time, tick_time
//  out_ch  | out       | kind, fired_id, fired_time, last, pending
//
// An add's result sits in the output register in the cycle after it is taken.
// A tick runs a count pass over the stored events and, if any is due, a compaction
// pass that fires them, one entry read per cycle while the output is not stalled.
// Reset is synchronous and active low; it empties the queue, not the memory.
// A stalled output register pauses compaction only on entries that fire; a new
// item is taken when the engine is idle and the output register is free or draining.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timed_kill_event_queue_top import tkeq_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  tkeq_in_if.sink   in_ch,
  tkeq_out_if.source out_ch
);

  cmd_t cmd;
  res_t res;
  logic eng_idle;
  logic slot_free;

  logic              out_valid_r, out_valid_nxt;
  kind_t             kind_r;
  logic [ID_W-1:0]   fired_id_r;
  logic [TIME_W-1:0] fired_time_r;
  logic              last_r;
  logic              pending_r;

  // The output register frees up in the same cycle its transfer completes.
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = eng_idle && slot_free;

  assign cmd.valid      = in_ch.valid && in_ch.ready;
  assign cmd.action     = act_t'(in_ch.action);
  assign cmd.target_id  = in_ch.target_id;
  assign cmd.event_time = in_ch.event_time;
  assign cmd.tick_time  = in_ch.tick_time;

  tkeq_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .slot_free_i (slot_free),
    .idle_o      (eng_idle),
    .res_o       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload is loaded only with a new result; no reset needed.
  always_ff @(posedge clk) begin
    if (res.valid) begin
      kind_r       <= res.kind;
      fired_id_r   <= res.fired_id;
      fired_time_r <= res.fired_time;
      last_r       <= res.last;
      pending_r    <= res.pending;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.fired_id   = fired_id_r;
  assign out_ch.fired_time = fired_time_r;
  assign out_ch.last       = last_r;
  assign out_ch.pending    = pending_r;

  `TKEQ_ASSERT(a_in_needs_slot, in_ch.ready |-> slot_free, "input taken with output blocked")
  `TKEQ_ASSERT(a_tick_busy, (cmd.valid && cmd.action == ACT_TICK) |=> !in_ch.ready,
               "input taken while a tick is in progress")
  `TKEQ_ASSERT(a_single_last, (out_valid_r && kind_r != KIND_FIRED) |-> last_r,
               "non-fired result without last")

endmodule

>>> src/tkeq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered and held when idle.
// ----------------------------------------------------------------------------
module tkeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/tkeq_engine.sv
// ----------------------------------------------------------------------------
// Timed kill event queue engine
// Sequencer over the event memory: append, count pass and compaction pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tkeq_engine import tkeq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd_i,
  input  logic slot_free_i,
  output logic idle_o,
  output res_t res_o
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              v_r, v_nxt;
  logic [CNT_W-1:0]  fire_tot_r, fire_tot_nxt;
  logic [CNT_W-1:0]  keep_tot_r, keep_tot_nxt;
  logic [CNT_W-1:0]  fire_seen_r, fire_seen_nxt;
  logic [CNT_W-1:0]  keep_idx_r, keep_idx_nxt;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [ID_W-1:0]   rd_id;
  logic [TIME_W-1:0] rd_time;
  logic              is_due, is_later, more_reads, consume;

  tkeq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_id      = ram_rdata[ENTRY_W-1:TIME_W];
  assign rd_time    = ram_rdata[TIME_W-1:0];
  assign is_due     = (rd_time == now_r);
  assign is_later   = (rd_time > now_r);
  assign more_reads = (rd_idx_r < count_r);
  assign consume    = v_r && (!is_due || slot_free_i);
  assign idle_o     = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      v_r     <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    rd_idx_r    <= rd_idx_nxt;
    fire_tot_r  <= fire_tot_nxt;
    keep_tot_r  <= keep_tot_nxt;
    fire_seen_r <= fire_seen_nxt;
    keep_idx_r  <= keep_idx_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    now_nxt       = now_r;
    rd_idx_nxt    = rd_idx_r;
    v_nxt         = v_r;
    fire_tot_nxt  = fire_tot_r;
    keep_tot_nxt  = keep_tot_r;
    fire_seen_nxt = fire_seen_r;
    keep_idx_nxt  = keep_idx_r;

    ram_we    = 1'b0;
    ram_waddr = count_r[ADDR_W-1:0];
    ram_wdata = {cmd_i.target_id, cmd_i.event_time};
    ram_re    = 1'b0;
    ram_raddr = rd_idx_r[ADDR_W-1:0];

    res_o = '{valid: 1'b0, kind: KIND_NONE, fired_id: '0, fired_time: '0,
              last: 1'b1, pending: 1'b0};

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          if (cmd_i.action == ACT_ADD) begin
            res_o.valid   = 1'b1;
            res_o.pending = 1'b1;
            if (count_r < CNT_W'(DEPTH)) begin
              ram_we    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              res_o.kind = KIND_ADD_OK;
            end else begin
              res_o.kind = KIND_ADD_FULL;
            end
          end else begin
            now_nxt      = cmd_i.tick_time;
            rd_idx_nxt   = '0;
            v_nxt        = 1'b0;
            fire_tot_nxt = '0;
            keep_tot_nxt = '0;
            state_nxt    = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (v_r) begin
          if (is_due) begin
            fire_tot_nxt = fire_tot_r + CNT_W'(1);
          end else if (is_later) begin
            keep_tot_nxt = keep_tot_r + CNT_W'(1);
          end
        end
        if (more_reads) begin
          ram_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
          v_nxt      = 1'b1;
        end else begin
          v_nxt = 1'b0;
          if (!v_r) begin
            rd_idx_nxt    = '0;
            fire_seen_nxt = '0;
            keep_idx_nxt  = '0;
            state_nxt     = (fire_tot_r == '0) ? ST_NONE : ST_EMIT;
          end
        end
      end

      ST_NONE: begin
        if (slot_free_i) begin
          res_o.valid   = 1'b1;
          res_o.kind    = KIND_NONE;
          res_o.pending = (count_r != '0);
          state_nxt     = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (v_r && is_due && slot_free_i) begin
          res_o.valid      = 1'b1;
          res_o.kind       = KIND_FIRED;
          res_o.fired_id   = rd_id;
          res_o.fired_time = rd_time;
          res_o.last       = ((fire_seen_r + CNT_W'(1)) == fire_tot_r);
          res_o.pending    = (keep_tot_r != '0);
          fire_seen_nxt    = fire_seen_r + CNT_W'(1);
        end
        // Survivors slide down; the write slot never passes the read pointer.
        if (consume && is_later) begin
          ram_we       = 1'b1;
          ram_waddr    = keep_idx_r[ADDR_W-1:0];
          ram_wdata    = ram_rdata;
          keep_idx_nxt = keep_idx_r + CNT_W'(1);
        end
        if ((!v_r || consume) && more_reads) begin
          ram_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
          v_nxt      = 1'b1;
        end else if (consume) begin
          v_nxt = 1'b0;
        end
        if (!v_r && !more_reads) begin
          count_nxt = keep_tot_r;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `TKEQ_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "event count above depth")
  `TKEQ_ASSERT(a_res_has_slot, res_o.valid |-> slot_free_i, "result with no free slot")
  `TKEQ_ASSERT(a_keep_bound, (state_r == ST_EMIT) |-> (keep_idx_r <= keep_tot_r),
               "compaction wrote more survivors than counted")
  `TKEQ_ASSERT(a_fire_bound, (state_r == ST_EMIT) |-> (fire_seen_r <= fire_tot_r),
               "more events fired than counted")

endmodule
